// ----- hw/rtl/itrd_pkg.sv -----
// itrd_pkg: types and constants for the integer to radix digits block.
// No dependencies; imported by every module of the block.
`default_nettype none

package itrd_pkg;

  // Fixed field widths
  localparam int RADIX_W    = 6;   // radix register width
  localparam int DIGIT_W    = 5;   // digit index width (up to 32 symbols)
  localparam int SYM_W      = 8;   // character byte
  localparam int CFG_ADDR_W = 6;   // byte address of five 64-bit registers
  localparam int CFG_DATA_W = 64;
  localparam int ALPHA_WORDS = 4;
  localparam int REG_IDX_W  = 3;

  // Register indexes (byte address = 8 * index)
  typedef enum logic [REG_IDX_W-1:0] {
    REG_RADIX  = 3'd0,
    REG_ALPHA0 = 3'd1,
    REG_ALPHA1 = 3'd2,
    REG_ALPHA2 = 3'd3,
    REG_ALPHA3 = 3'd4
  } reg_idx_t;

  // Reset values
  localparam logic [RADIX_W-1:0]    RADIX_RST  = 6'd10;
  localparam logic [CFG_DATA_W-1:0] ALPHA0_RST = 64'd4050765991979987505;
  localparam logic [CFG_DATA_W-1:0] ALPHA1_RST = 64'd14648;
  localparam logic [CFG_DATA_W-1:0] ALPHA2_RST = 64'd0;
  localparam logic [CFG_DATA_W-1:0] ALPHA3_RST = 64'd0;

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [SYM_W-1:0]   MINUS_CHAR = 8'h2D;

  typedef logic [ALPHA_WORDS-1:0][CFG_DATA_W-1:0] alphabet_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } seq_state_t;

  // Pick one symbol byte out of the alphabet words
  function automatic logic [SYM_W-1:0] sym_lookup(input alphabet_t alpha,
                                                  input logic [DIGIT_W-1:0] d);
    logic [ALPHA_WORDS*CFG_DATA_W-1:0] flat;
    flat = alpha;
    return flat[{d, 3'b000} +: SYM_W];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/itrd_cfg.sv -----
// itrd_cfg: APB-style register file holding the radix and the alphabet words.
// Depends on itrd_pkg.
`default_nettype none

module itrd_cfg (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [itrd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire [itrd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [itrd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [itrd_pkg::RADIX_W-1:0]  radix,
  output itrd_pkg::alphabet_t           alphabet
);
  import itrd_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  alphabet_t          alpha_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RST;
      alpha_r[0] <= ALPHA0_RST;
      alpha_r[1] <= ALPHA1_RST;
      alpha_r[2] <= ALPHA2_RST;
      alpha_r[3] <= ALPHA3_RST;
    end else if (wr_en) begin
      case (idx)
        REG_RADIX:  radix_r    <= pwdata[RADIX_W-1:0];
        REG_ALPHA0: alpha_r[0] <= pwdata;
        REG_ALPHA1: alpha_r[1] <= pwdata;
        REG_ALPHA2: alpha_r[2] <= pwdata;
        REG_ALPHA3: alpha_r[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_RADIX:  prdata = {{(CFG_DATA_W-RADIX_W){1'b0}}, radix_r};
      REG_ALPHA0: prdata = alpha_r[0];
      REG_ALPHA1: prdata = alpha_r[1];
      REG_ALPHA2: prdata = alpha_r[2];
      REG_ALPHA3: prdata = alpha_r[3];
      default:    prdata = '0;
    endcase
  end

  assign radix    = radix_r;
  assign alphabet = alpha_r;

endmodule

`default_nettype wire

// ----- hw/rtl/itrd_divider.sv -----
// itrd_divider: bit-serial restoring divider, one quotient bit per cycle.
// Divides a VALUE_BITS-bit magnitude by a radix of at most 32. Depends on itrd_pkg.
`default_nettype none

module itrd_divider #(
  parameter int VALUE_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire [VALUE_BITS-1:0]         dividend,
  input  wire [itrd_pkg::RADIX_W-1:0]  divisor,
  output logic                         done,
  output logic [VALUE_BITS-1:0]        quotient,
  output logic [itrd_pkg::DIGIT_W-1:0] remainder
);
  import itrd_pkg::*;

  localparam int STEP_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r;
  logic                  done_r;
  logic [RADIX_W-1:0]    trial;
  logic [RADIX_W-1:0]    diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial   = {rem_r, quo_r[VALUE_BITS-1]};
  assign fits    = (trial >= divisor);
  assign diff    = trial - divisor;
  assign quo_nxt = {quo_r[VALUE_BITS-2:0], fits};
  assign rem_nxt = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(VALUE_BITS - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r - 1'b1;
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_radix_digits_top.sv -----
// Channel   Direction  Ports                         Transaction
// input     in         in_valid/in_stall, in_value   one signed value to convert
// output    out        out_valid/out_stall, out_*    one character, last flag on final
// config    in/out     psel..pready (APB, 64-bit)    radix at 0x00, alphabet at 0x08..0x20
//
// Each digit takes one pass of the shared bit-serial divider; each digit
// character then takes a digit store read and an output load, and a minus
// sign takes one output load.
// Reset is synchronous, active low; the digit store needs no clearing.
// A stalled output holds its character; the next value is taken while it waits.
// Depends on itrd_pkg, itrd_cfg and itrd_divider.
`default_nettype none

module integer_to_radix_digits_top #(
  parameter int MAX_RADIX  = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // input channel
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire signed [VALUE_BITS-1:0]    in_value,
  // result channel
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [itrd_pkg::SYM_W-1:0]     out_symbol,
  output logic                           out_last,
  // configuration
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [itrd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire [itrd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [itrd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import itrd_pkg::*;

  localparam int AW    = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  seq_state_t state_r, state_nxt;

  logic [RADIX_W-1:0]    radix;
  alphabet_t             alphabet;
  logic [RADIX_W-1:0]    eff_radix;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quo;
  logic [DIGIT_W-1:0]    div_rem;

  logic [VALUE_BITS-1:0] in_mag;
  logic                  in_acc;
  logic                  more;
  logic                  out_free;
  logic                  mem_we;
  logic                  load_minus;
  logic                  load_digit;

  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  neg_r;

  logic [DIGIT_W-1:0]    mem [VALUE_BITS];
  logic [DIGIT_W-1:0]    rd_data_r;

  logic                  out_valid_r;
  logic [SYM_W-1:0]      out_symbol_r;
  logic                  out_last_r;

  // Configuration registers
  itrd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .radix    (radix),
    .alphabet (alphabet)
  );

  // Clamp radix to [2, MAX_RADIX]
  always_comb begin
    eff_radix = radix;
    if (eff_radix < RADIX_MIN) eff_radix = RADIX_MIN;
    if (eff_radix > RADIX_W'(MAX_RADIX)) eff_radix = RADIX_W'(MAX_RADIX);
  end

  // Magnitude taken as unsigned, so the most negative value is exact
  assign in_mag = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;

  assign in_acc       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign more         = (div_quo != '0) && (cnt_r != CNT_W'(VALUE_BITS - 1));
  assign div_dividend = (state_r == ST_IDLE) ? in_mag : div_quo;
  assign cnt_m1       = cnt_r - 1'b1;

  itrd_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (eff_radix),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done && !more) state_nxt = neg_r ? ST_SIGN : ST_READ;
      end
      ST_SIGN:   if (out_free) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_READ;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall   = 1'b1;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    load_minus = 1'b0;
    load_digit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = !rst_n;
        div_start = in_valid && rst_n;
      end
      ST_DIVIDE: begin
        mem_we    = div_done;
        div_start = div_done && more;
      end
      ST_SIGN:  load_minus = out_free;
      ST_READ:  ;
      ST_EMIT:  load_digit = out_free;
      default:  ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        cnt_r <= '0;
        neg_r <= in_value[VALUE_BITS-1];
      end else if (mem_we) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (load_digit) begin
        cnt_r <= cnt_m1;
      end
    end
  end

  // Digit store, least significant digit at address zero
  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_r[AW-1:0]] <= div_rem;
    rd_data_r <= mem[cnt_m1[AW-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_minus || load_digit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_minus) begin
      out_symbol_r <= MINUS_CHAR;
      out_last_r   <= 1'b0;
    end else if (load_digit) begin
      out_symbol_r <= sym_lookup(alphabet, rd_data_r);
      out_last_r   <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/itrd_checker.sv -----
// itrd_checker: port-level assertions for integer_to_radix_digits_top, with bind.
// Depends on itrd_pkg and integer_to_radix_digits_top.
`default_nettype none

module itrd_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_stall,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire [itrd_pkg::SYM_W-1:0]  out_symbol,
  input wire                        out_last
);
  import itrd_pkg::*;

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("output changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The divider is busy: no new value right after one is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken during conversion");

endmodule

bind integer_to_radix_digits_top itrd_checker u_itrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_symbol (out_symbol),
  .out_last   (out_last)
);

`default_nettype wire
